>>> rtl/ase_pkg.sv
// Package for the execute unit: opcode, status and branch condition codes,
// register file size and parameter defaults. No dependencies.
`timescale 1ns / 1ps
package ase_pkg;

   localparam int NUM_REGS        = 13;
   localparam int REG_IDX_BITS    = 4;
   localparam int DATA_WORDS_DEF  = 128;
   localparam int STACK_WORDS_DEF = 32;
   localparam int PROG_BITS_DEF   = 10;

   typedef enum logic [3:0] {
      FN_MOV = 4'd0,
      FN_ADD = 4'd1,
      FN_SUB = 4'd2,
      FN_MUL = 4'd3,
      FN_LDR = 4'd4,
      FN_STR = 4'd5,
      FN_CMP = 4'd6,
      FN_B   = 4'd7,
      FN_BL  = 4'd8
   } func_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_DATA   = 2'd1,
      ST_STACK  = 2'd2,
      ST_BAD_SP = 2'd3
   } status_type;

   localparam logic [1:0] COND_BNE = 2'd1;
   localparam logic [1:0] COND_BGE = 2'd2;

endpackage

>>> rtl/ase_regfile.sv
// General register file: 13 x 32 memory, two registered read ports, one write
// port with write-through on a same-edge read. Depends on ase_pkg.
`timescale 1ns / 1ps
module ase_regfile
   import ase_pkg::*;
(
   input  logic                    clock,
   input  logic                    rd_en,
   input  logic [REG_IDX_BITS-1:0] rd_addr_a,
   input  logic [REG_IDX_BITS-1:0] rd_addr_b,
   input  logic                    wr_en,
   input  logic [REG_IDX_BITS-1:0] wr_addr,
   input  logic [31:0]             wr_data,
   output logic [31:0]             rd_data_a,
   output logic [31:0]             rd_data_b
);

   logic [31:0] mem [NUM_REGS];
   logic [31:0] a_ff, b_ff;
   logic        a_zero_ff, b_zero_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         a_zero_ff <= (32'(rd_addr_a) >= 32'(NUM_REGS));
         b_zero_ff <= (32'(rd_addr_b) >= 32'(NUM_REGS));
         a_ff      <= (wr_en && wr_addr == rd_addr_a) ? wr_data : mem[rd_addr_a];
         b_ff      <= (wr_en && wr_addr == rd_addr_b) ? wr_data : mem[rd_addr_b];
      end
   end

   assign rd_data_a = a_zero_ff ? 32'd0 : a_ff;
   assign rd_data_b = b_zero_ff ? 32'd0 : b_ff;

endmodule

>>> rtl/ase_ram.sv
// Word memory for data and stack: one write port, one registered read port,
// write-through when both hit the same word on one edge. Depends on ase_pkg.
`timescale 1ns / 1ps
module ase_ram
   import ase_pkg::*;
#(
   parameter int DEPTH = DATA_WORDS_DEF,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   output logic [31:0]   rd_data
);

   logic [31:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= (wr_en && wr_addr == rd_addr) ? wr_data : mem[rd_addr];
      end
   end

endmodule

>>> rtl/arm_subset_execute_unit.sv
// Execute unit for a small ARM-like instruction subset: top level with the
// three-stage pipeline. Depends on ase_pkg, ase_regfile and ase_ram.
//
//   channel | dir | handshake          | payload
//   req_    | in  | req_valid/ready    | one decoded instruction
//   rsp_    | out | rsp_valid/ready    | status, branch, target, written value
//
// rsp_valid rises once the item has passed both stages: the operands are read at
// acceptance, stage 1 executes and reads memory, stage 2 writes back and loads
// the output register. A new item is accepted every cycle while rsp_ready does not
// hold the pipeline; results of the item ahead are forwarded.
// After reset a clearing pass over max(DATA_WORDS, STACK_WORDS) words zeroes
// registers, data and stack memory; req_ready stays low meanwhile.
// A stalled rsp_ holds the whole pipeline.
`timescale 1ns / 1ps
module arm_subset_execute_unit
   import ase_pkg::*;
#(
   parameter int DATA_WORDS      = DATA_WORDS_DEF,
   parameter int STACK_WORDS     = STACK_WORDS_DEF,
   parameter int PROG_INDEX_BITS = PROG_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_func,
   input  logic [3:0]         req_dest_reg,
   input  logic [3:0]         req_src_reg_a,
   input  logic [3:0]         req_src_reg_b,
   input  logic [23:0]        req_immediate,
   input  logic               req_second_is_immediate,
   input  logic               req_dest_is_sp,
   input  logic               req_first_is_sp,
   input  logic [1:0]         req_branch_condition,
   input  logic [9:0]         req_branch_target,
   input  logic [9:0]         req_return_index,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic               rsp_branch_taken,
   output logic [9:0]         rsp_next_target,
   output logic signed [31:0] rsp_written_value
);

   localparam int DAW       = $clog2(DATA_WORDS);
   localparam int SAW       = $clog2(STACK_WORDS);
   localparam int CLR_WORDS = (DATA_WORDS > STACK_WORDS) ? DATA_WORDS : STACK_WORDS;
   localparam int CLR_BITS  = $clog2(CLR_WORDS);
   localparam logic [9:0] PMASK =
      (PROG_INDEX_BITS >= 10) ? 10'h3FF : 10'((1 << PROG_INDEX_BITS) - 1);

   // clearing pass
   logic                clr_ff, clr_in;
   logic [CLR_BITS-1:0] clr_cnt_ff, clr_cnt_in;

   // pipeline advance: all stages move together
   logic adv;

   // stage 1: operands read
   logic        s1_valid_ff, s1_valid_in;
   func_type    s1_func_ff;
   logic [3:0]  s1_rd_ff, s1_ra_ff, s1_rb_ff;
   logic [23:0] s1_imm_ff;
   logic        s1_is_imm_ff, s1_d_sp_ff, s1_f_sp_ff;
   logic [1:0]  s1_cond_ff;
   logic [9:0]  s1_target_ff, s1_ret_ff;

   // stage 2: memory read, write-back
   logic        s2_valid_ff;
   logic [1:0]  s2_status_ff;
   logic        s2_taken_ff;
   logic [9:0]  s2_target_ff;
   logic [31:0] s2_wv_ff;
   logic        s2_load_ff, s2_load_stk_ff;
   logic        s2_reg_we_ff, s2_sp_we_ff, s2_dat_we_ff, s2_stk_we_ff, s2_lr_we_ff;
   logic [3:0]  s2_reg_idx_ff;
   logic [32:0] s2_addr_ff;
   logic [9:0]  s2_lr_ff;

   // architectural flops
   logic [31:0]                sp_ff;
   logic [PROG_INDEX_BITS-1:0] lr_ff;

   // output register
   logic        out_valid_ff;
   logic [1:0]  out_status_ff;
   logic        out_taken_ff;
   logic [9:0]  out_target_ff;
   logic [31:0] out_wv_ff;

   // memory ports
   logic [31:0] rf_a, rf_b, dat_q, stk_q;
   logic        rf_we, dat_we, stk_we;
   logic [3:0]  rf_waddr;
   logic [31:0] rf_wdata, mem_wdata;
   logic [DAW-1:0] dat_waddr;
   logic [SAW-1:0] stk_waddr;

   // stage 1 execute results
   logic [31:0] opa, opb, sp_cur, imm32, base, wv1, bsel;
   logic [32:0] addr, lhs, rhs;
   logic [1:0]  st1;
   logic        taken1, load1, load_stk1, reg_we1, sp_we1, dat_we1, stk_we1, lr_we1;
   logic [31:0] s2_wv;

   assign adv       = !out_valid_ff || rsp_ready;
   assign req_ready = adv && !clr_ff;

   // ------------------------------------------------------------ clearing pass
   always_comb begin
      clr_in     = clr_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clr_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (32'(clr_cnt_ff) == CLR_WORDS - 1) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
      end else begin
         clr_ff     <= clr_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // ------------------------------------------------------------ memories
   // Port B of the register file serves the stored register of str.
   ase_regfile u_regfile (
      .clock     (clock),
      .rd_en     (adv),
      .rd_addr_a (req_src_reg_a),
      .rd_addr_b ((req_func == FN_STR) ? req_dest_reg : req_src_reg_b),
      .wr_en     (rf_we),
      .wr_addr   (rf_waddr),
      .wr_data   (rf_wdata),
      .rd_data_a (rf_a),
      .rd_data_b (rf_b)
   );

   ase_ram #(.DEPTH(DATA_WORDS)) u_data_ram (
      .clock   (clock),
      .rd_en   (adv),
      .rd_addr (addr[DAW-1:0]),
      .wr_en   (dat_we),
      .wr_addr (dat_waddr),
      .wr_data (mem_wdata),
      .rd_data (dat_q)
   );

   ase_ram #(.DEPTH(STACK_WORDS)) u_stack_ram (
      .clock   (clock),
      .rd_en   (adv),
      .rd_addr (addr[SAW-1:0]),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (mem_wdata),
      .rd_data (stk_q)
   );

   // Write ports: the clearing pass, else stage 2 write-back.
   always_comb begin
      if (clr_ff) begin
         rf_we     = 32'(clr_cnt_ff) < NUM_REGS;
         rf_waddr  = clr_cnt_ff[3:0];
         rf_wdata  = '0;
         dat_we    = 32'(clr_cnt_ff) < DATA_WORDS;
         dat_waddr = clr_cnt_ff[DAW-1:0];
         stk_we    = 32'(clr_cnt_ff) < STACK_WORDS;
         stk_waddr = clr_cnt_ff[SAW-1:0];
         mem_wdata = '0;
      end else begin
         rf_we     = adv && s2_valid_ff && s2_reg_we_ff;
         rf_waddr  = s2_reg_idx_ff;
         rf_wdata  = s2_wv;
         dat_we    = adv && s2_valid_ff && s2_dat_we_ff;
         dat_waddr = s2_addr_ff[DAW-1:0];
         stk_we    = adv && s2_valid_ff && s2_stk_we_ff;
         stk_waddr = s2_addr_ff[SAW-1:0];
         mem_wdata = s2_wv_ff;
      end
   end

   // ------------------------------------------------------------ stage 1
   assign s1_valid_in = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_func_ff   <= func_type'(req_func);
         s1_rd_ff     <= req_dest_reg;
         s1_ra_ff     <= req_src_reg_a;
         s1_rb_ff     <= (req_func == FN_STR) ? req_dest_reg : req_src_reg_b;
         s1_imm_ff    <= req_immediate;
         s1_is_imm_ff <= req_second_is_immediate;
         s1_d_sp_ff   <= req_dest_is_sp;
         s1_f_sp_ff   <= req_first_is_sp;
         s1_cond_ff   <= req_branch_condition;
         s1_target_ff <= req_branch_target & PMASK;
         s1_ret_ff    <= req_return_index & PMASK;
      end
   end

   // Forward the item one ahead; stage 2 writes only when it advances.
   always_comb begin
      opa    = (s2_valid_ff && s2_reg_we_ff && s2_reg_idx_ff == s1_ra_ff) ? s2_wv : rf_a;
      opb    = (s2_valid_ff && s2_reg_we_ff && s2_reg_idx_ff == s1_rb_ff) ? s2_wv : rf_b;
      sp_cur = (s2_valid_ff && s2_sp_we_ff) ? s2_wv_ff : sp_ff;
      imm32  = {8'd0, s1_imm_ff};
      base   = s1_f_sp_ff ? sp_cur : opa;
      addr   = {base[31], base} + {9'd0, s1_imm_ff};
      lhs    = {opa[31], opa};
      rhs    = s1_is_imm_ff ? {1'b0, imm32} : {opb[31], opb};
      bsel   = s1_is_imm_ff ? imm32 : opb;
   end

   always_comb begin
      st1       = ST_OK;
      taken1    = 1'b0;
      load1     = 1'b0;
      load_stk1 = 1'b0;
      reg_we1   = 1'b0;
      sp_we1    = 1'b0;
      dat_we1   = 1'b0;
      stk_we1   = 1'b0;
      lr_we1    = 1'b0;
      wv1       = '0;
      unique case (s1_func_ff)
         FN_MOV: begin
            wv1     = s1_is_imm_ff ? imm32 : opa;
            reg_we1 = 1'b1;
         end
         FN_ADD, FN_SUB: begin
            if (s1_d_sp_ff || s1_f_sp_ff) begin
               if (s1_d_sp_ff && s1_f_sp_ff && s1_is_imm_ff) begin
                  wv1    = (s1_func_ff == FN_ADD) ? sp_cur + imm32 : sp_cur - imm32;
                  sp_we1 = 1'b1;
               end else begin
                  st1 = ST_BAD_SP;
               end
            end else begin
               wv1     = (s1_func_ff == FN_ADD) ? opa + bsel : opa - bsel;
               reg_we1 = 1'b1;
            end
         end
         FN_MUL: begin
            wv1     = opa * opb;
            reg_we1 = 1'b1;
         end
         FN_LDR, FN_STR: begin
            if (addr[32] || addr >= (s1_f_sp_ff ? 33'(STACK_WORDS) : 33'(DATA_WORDS))) begin
               st1 = s1_f_sp_ff ? ST_STACK : ST_DATA;
            end else if (s1_func_ff == FN_LDR) begin
               load1     = 1'b1;
               load_stk1 = s1_f_sp_ff;
               reg_we1   = 1'b1;
            end else begin
               wv1     = opb;
               stk_we1 = s1_f_sp_ff;
               dat_we1 = !s1_f_sp_ff;
            end
         end
         FN_CMP: begin
            taken1 = (s1_cond_ff == COND_BNE && lhs != rhs) ||
                     (s1_cond_ff == COND_BGE && $signed(lhs) >= $signed(rhs));
         end
         FN_B: begin
            taken1 = 1'b1;
         end
         FN_BL: begin
            taken1 = 1'b1;
            lr_we1 = 1'b1;
            wv1    = {22'd0, s1_ret_ff};
         end
         default: begin
         end
      endcase
      // drop writes to indexes beyond the register file
      if (32'(s1_rd_ff) >= NUM_REGS) begin
         reg_we1 = 1'b0;
      end
   end

   // ------------------------------------------------------------ stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_status_ff   <= st1;
         s2_taken_ff    <= taken1;
         s2_target_ff   <= s1_target_ff;
         s2_wv_ff       <= wv1;
         s2_load_ff     <= load1;
         s2_load_stk_ff <= load_stk1;
         s2_reg_we_ff   <= reg_we1;
         s2_sp_we_ff    <= sp_we1;
         s2_dat_we_ff   <= dat_we1;
         s2_stk_we_ff   <= stk_we1;
         s2_lr_we_ff    <= lr_we1;
         s2_reg_idx_ff  <= s1_rd_ff;
         s2_addr_ff     <= addr;
         s2_lr_ff       <= s1_ret_ff;
      end
   end

   // merge load data, which arrives from the memories this cycle
   assign s2_wv = s2_load_ff ? (s2_load_stk_ff ? stk_q : dat_q) : s2_wv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= 32'(STACK_WORDS - 2);
         lr_ff <= '0;
      end else if (adv && s2_valid_ff) begin
         if (s2_sp_we_ff) begin
            sp_ff <= s2_wv_ff;
         end
         if (s2_lr_we_ff) begin
            lr_ff <= PROG_INDEX_BITS'(s2_lr_ff);
         end
      end
   end

   // ------------------------------------------------------------ output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_status_ff <= s2_status_ff;
         out_taken_ff  <= s2_taken_ff;
         out_target_ff <= s2_taken_ff ? s2_target_ff : 10'd0;
         out_wv_ff     <= s2_wv;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_branch_taken  = out_taken_ff;
   assign rsp_next_target   = out_target_ff;
   assign rsp_written_value = $signed(out_wv_ff);

   // ------------------------------------------------------------ assertions
   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !req_ready)
      else $error("item accepted during clearing pass");

   a_error_no_effect: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_written_value == 0 && !rsp_branch_taken)
      else $error("failed item reports a write or branch");

   a_target_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_branch_taken |-> rsp_next_target == 10'd0)
      else $error("target given without branch");

   a_lr_follows_bl: assert property (@(posedge clock) disable iff (reset)
      adv && s2_valid_ff && s2_lr_we_ff |=> lr_ff == PROG_INDEX_BITS'(out_wv_ff))
      else $error("link register differs from reported value");

endmodule
